[sv/wfd_pkg.sv]
// ----------------------------------------------------------------------------
// wfd_pkg
// shared types and constants of the weighted flap detector: field widths,
// register indexes and the command and status bundles between control and
// datapath
// ----------------------------------------------------------------------------
`default_nettype none

package wfd_pkg;

	localparam int PCT_W       = 15;
	localparam int MASK_W      = 4;
	localparam int STATE_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int PCT_MAX     = 25600;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_MSK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_EN = 2'd3;

	// observed state codes
	localparam logic [STATE_W-1:0] OBS_OK = 2'd0;

	typedef struct packed {
		logic accept;
		logic walk_start;
		logic walk_step;
		logic scale;
		logic finish;
	} wfd_cmd_t;

	typedef struct packed {
		logic skip;
		logic walk_last;
	} wfd_sts_t;

endpackage

`default_nettype wire

[sv/wfd_dp.sv]
// ----------------------------------------------------------------------------
// wfd_dp
// datapath: config registers, ring history, weighted transition walk,
// reciprocal scaling and hysteresis decision with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_dp import wfd_pkg::*; #(
	parameter int HISTORY_DEPTH = 21
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [STATE_W-1:0]    obs_state,
	input  wire logic                  soft_req,
	input  wire logic                  update,
	input  wire wfd_cmd_t              cmd,
	output wfd_sts_t                   sts,
	output logic [PCT_W-1:0]           change_pct,
	output logic                       flapping,
	output logic                       started,
	output logic                       stopped,
	output logic                       ignored
);

	localparam int N      = HISTORY_DEPTH;
	localparam int IDX_W  = $clog2(N);
	localparam int CNT_W  = $clog2(N - 1);
	localparam int WGT_W  = $clog2(5 * (N - 2) + 1);
	localparam int SUM_W  = $clog2(4 * (N - 1) * (N - 2) + 1);
	localparam int DIV_D  = (N - 2) * (N - 1);
	// rounded-up reciprocal of DIV_D times 6400; the shift keeps the error
	// below one step of the quotient for every sum up to 4 * DIV_D
	localparam int RCP_SH = $clog2(4 * DIV_D * DIV_D) + 1;
	localparam longint unsigned RCP_M =
		((64'd6400 << RCP_SH) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
	localparam int RCP_W  = $clog2(RCP_M + 64'd1);
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_M);

	// config
	logic [PCT_W-1:0]  low_thr_q, high_thr_q;
	logic [MASK_W-1:0] track_mask_q;
	logic              detect_en_q;

	// history and item state
	logic [STATE_W-1:0] hist_q [N];
	logic [IDX_W-1:0]   slot_q;
	logic               skip_q;
	logic [PCT_W-1:0]   last_pct_q;
	logic               flap_q;

	// walk
	logic [IDX_W-1:0]   pos_q;
	logic [STATE_W-1:0] prev_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WGT_W-1:0]   wgt_q;
	logic [SUM_W-1:0]   sum_q;

	// scaling
	logic [PROD_W-1:0]  prod_q;

	logic               item_skip, item_rec;
	logic [IDX_W-1:0]   slot_nx, pos_nx;
	logic [STATE_W-1:0] cur_st;
	logic [PCT_W-1:0]   pct_calc;
	logic [PCT_W-1:0]   pct_sel;
	logic               flag_nx, start_nx, stop_nx;

	assign item_skip = soft_req && (obs_state != OBS_OK);
	assign item_rec  = !item_skip && update && track_mask_q[obs_state];
	assign slot_nx   = (slot_q == IDX_W'(N - 1)) ? '0 : slot_q + 1'b1;
	assign pos_nx    = (pos_q == IDX_W'(N - 1)) ? '0 : pos_q + 1'b1;
	assign cur_st    = hist_q[pos_nx];

	// floor(sum * 6400 / DIV_D) from the registered product
	assign pct_calc = prod_q[RCP_SH +: PCT_W];

	assign sts.skip      = skip_q;
	assign sts.walk_last = cnt_q == CNT_W'(N - 2);

	// hysteresis
	assign pct_sel = skip_q ? last_pct_q : pct_calc;
	always_comb begin
		flag_nx  = flap_q;
		start_nx = 1'b0;
		stop_nx  = 1'b0;
		if (!skip_q && detect_en_q) begin
			if (pct_sel <= low_thr_q) begin
				stop_nx = flap_q;
				flag_nx = 1'b0;
			end else if (pct_sel >= high_thr_q) begin
				start_nx = !flap_q;
				flag_nx  = 1'b1;
			end
		end
		if (!detect_en_q)
			flag_nx = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q    <= PCT_W'(1280);
			high_thr_q   <= PCT_W'(5120);
			track_mask_q <= '1;
			detect_en_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LOW_THR:   low_thr_q    <= cfg_wdata[PCT_W-1:0];
				CFG_HIGH_THR:  high_thr_q   <= cfg_wdata[PCT_W-1:0];
				CFG_TRACK_MSK: track_mask_q <= cfg_wdata[MASK_W-1:0];
				CFG_DETECT_EN: detect_en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				hist_q[i] <= OBS_OK;
			slot_q     <= '0;
			last_pct_q <= '0;
			flap_q     <= 1'b0;
		end else begin
			if (cmd.accept && item_rec) begin
				hist_q[slot_q] <= obs_state;
				slot_q         <= slot_nx;
			end
			if (cmd.finish) begin
				flap_q <= flag_nx;
				if (!skip_q)
					last_pct_q <= pct_calc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			skip_q <= item_skip;
		if (cmd.walk_start) begin
			pos_q  <= slot_q;
			prev_q <= hist_q[slot_q];
			cnt_q  <= '0;
			wgt_q  <= WGT_W'(3 * (N - 2));
			sum_q  <= '0;
		end else if (cmd.walk_step) begin
			pos_q  <= pos_nx;
			prev_q <= cur_st;
			cnt_q  <= cnt_q + 1'b1;
			wgt_q  <= wgt_q + WGT_W'(2);
			if (cur_st != prev_q)
				sum_q <= sum_q + SUM_W'(wgt_q);
		end
		// constant multiply, sum width by reciprocal width
		if (cmd.scale)
			prod_q <= PROD_W'(sum_q) * PROD_W'(RCP_K);
		if (cmd.finish) begin
			change_pct <= pct_sel;
			flapping   <= flag_nx;
			started    <= start_nx;
			stopped    <= stop_nx;
			ignored    <= skip_q;
		end
	end

endmodule

`default_nettype wire

[sv/wfd_ctrl.sv]
// ----------------------------------------------------------------------------
// wfd_ctrl
// controller: sequences accept, history walk, scaling and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_ctrl import wfd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire wfd_sts_t sts,
	output wfd_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_WALK = 5'b00100,
		S_MUL  = 5'b01000,
		S_DONE = 5'b10000
	} wfd_state_t;

	wfd_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.walk_start = 1'b1;
				state_nx       = sts.skip ? S_DONE : S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last)
					state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.scale = 1'b1;
				state_nx  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[sv/weighted_flap_detector_unit.sv]
// ----------------------------------------------------------------------------
// weighted_flap_detector_unit
// weighted state change flap detector with hysteresis
// ----------------------------------------------------------------------------
// one request in gives one result out. a request is taken only while the unit
// is idle; a recorded (or merely re-evaluated) request goes through these steps
// in order: load the walk, walk over the ring history (one entry a cycle),
// scale by a multiply with a constant reciprocal, and decide and register the
// result. the unit is ready again in the cycle after the result is registered.
// a soft non-ok request skips the walk and the scaling and goes from the load
// straight to the result step. the result sits in an output register, so a new
// request is taken while the previous result still waits on out_ready; a result
// that cannot be handed off holds the unit in its last step. registers are to
// be written by the user through cfg_we / cfg_addr / cfg_wdata only while idle;
// the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_flap_detector_unit import wfd_pkg::*; #(
	parameter int HISTORY_DEPTH = 21
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// register write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [STATE_W-1:0]    obs_state,
	input  wire logic                  soft_req,
	input  wire logic                  update,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PCT_W-1:0]           change_pct,
	output logic                       flapping,
	output logic                       started,
	output logic                       stopped,
	output logic                       ignored
);

	// command and status bundles between sequencer and datapath
	wfd_cmd_t cmd;
	wfd_sts_t sts;

	// sequencer: owns the handshakes and steps the datapath
	wfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: history ring, weighted walk, scaling, hysteresis and result
	wfd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.obs_state      (obs_state),
		.soft_req       (soft_req),
		.update         (update),
		.cmd            (cmd),
		.sts            (sts),
		.change_pct     (change_pct),
		.flapping       (flapping),
		.started        (started),
		.stopped        (stopped),
		.ignored        (ignored)
	);

endmodule

`default_nettype wire

[sv/wfd_checker.sv]
// ----------------------------------------------------------------------------
// wfd_checker
// port-level checks on the flap detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_checker import wfd_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [PCT_W-1:0]      change_pct,
	input wire logic                  flapping,
	input wire logic                  started,
	input wire logic                  stopped,
	input wire logic                  ignored
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(change_pct)
			&& $stable(flapping) && $stable(started) && $stable(stopped))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a start leaves the flag set, a stop leaves it clear, never both
	a_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(started && !flapping) && !(stopped && flapping)
			&& !(started && stopped))
		else $error("start or stop disagrees with flag");

	// a skipped request makes no decision
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ignored |-> !started && !stopped)
		else $error("skipped request changed flap state");

	// percent stays in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> change_pct <= PCT_W'(PCT_MAX))
		else $error("percent out of range");

endmodule

bind weighted_flap_detector_unit wfd_checker u_wfd_checker (.*);

`default_nettype wire

[dv/tb_weighted_flap_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_flap_detector_unit
// self-checking bench: a directed table of requests and register writes, then
// segments of random flap bursts, steady runs and noise under changing
// settings and idle patterns; a typed table row is checked against its fixed
// result, every other result against a predictor of the weighted history and the hysteresis
// ----------------------------------------------------------------------------

module tb_weighted_flap_detector_unit;
	import wfd_pkg::*;

	localparam int DEPTH       = 21;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SEG_REQS    = 42;
	localparam int N_SEGS      = 8;
	localparam int DRAIN_WAIT  = 80;

	typedef enum logic [STATE_W-1:0] {
		ST_OK       = OBS_OK,
		ST_WARNING  = 2'd1,
		ST_CRITICAL = 2'd2,
		ST_UNKNOWN  = 2'd3
	} obs_t;

	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic             flapping;
		logic             started;
		logic             stopped;
		logic             ignored;
	} flap_res_t;

	// one directed row: either a register write or a request
	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] wdata;
		obs_t                  st;
		logic                  soft_flag;
		logic                  upd;
		logic                  typed;
		flap_res_t             res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [STATE_W-1:0]    obs_state;
	logic                  soft_req;
	logic                  update;
	logic                  out_valid;
	logic                  out_ready;
	logic [PCT_W-1:0]      change_pct;
	logic                  flapping;
	logic                  started;
	logic                  stopped;
	logic                  ignored;

	weighted_flap_detector_unit #(
		.HISTORY_DEPTH(DEPTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.obs_state      (obs_state),
		.soft_req       (soft_req),
		.update         (update),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.change_pct     (change_pct),
		.flapping       (flapping),
		.started        (started),
		.stopped        (stopped),
		.ignored        (ignored)
	);

	// predictor copy of the registers, reset values
	logic [PCT_W-1:0]   thr_low  = 15'd1280;
	logic [PCT_W-1:0]   thr_high = 15'd5120;
	logic [MASK_W-1:0]  track_mask = 4'hF;
	logic               det_en   = 1'b1;

	// predictor copy of the ring history and the flag
	logic [STATE_W-1:0] ring [DEPTH];
	int                 ring_wr  = 0;
	logic [PCT_W-1:0]   held_pct = '0;
	logic               flap_on  = 1'b0;

	flap_res_t pending_results[$];
	dir_row_t  dir_rows[$];

	int fails          = 0;
	int scored_reqs    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, reckoned well above the slowest legal run
	initial begin
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("weighted_flap_detector_unit: mismatch");
		$finish;
	end

	// weighted change over the ring, oldest entry at the write pointer;
	// weights climb linearly towards the newest pair
	function automatic logic [PCT_W-1:0] ring_change_pct();
		longint unsigned    wsum;
		int                 pos;
		logic [STATE_W-1:0] prev;
		wsum = 0;
		pos  = ring_wr;
		prev = ring[pos];
		for (int x = 1; x < DEPTH; x++) begin
			pos = (pos == DEPTH - 1) ? 0 : pos + 1;
			if (ring[pos] != prev)
				wsum += 3 * (DEPTH - 2) + 2 * (x - 1);
			prev = ring[pos];
		end
		return PCT_W'((wsum * 6400) / ((DEPTH - 2) * (DEPTH - 1)));
	endfunction

	// advance the predictor by one request and return its result
	function automatic flap_res_t flap_update(obs_t st, logic soft_in, logic upd);
		flap_res_t r;
		r = '0;
		if (soft_in && st != ST_OK) begin
			// soft non-ok: history and percent stay put
			r.ignored = 1'b1;
		end else begin
			if (upd && track_mask[st]) begin
				ring[ring_wr] = st;
				ring_wr = (ring_wr == DEPTH - 1) ? 0 : ring_wr + 1;
			end
			held_pct = ring_change_pct();
			if (det_en) begin
				// low side wins when the thresholds cross
				if (held_pct <= thr_low) begin
					r.stopped = flap_on;
					flap_on = 1'b0;
				end else if (held_pct >= thr_high) begin
					r.started = !flap_on;
					flap_on = 1'b1;
				end
			end
		end
		// detection off forces the flag low, not counted as a stop
		if (!det_en)
			flap_on = 1'b0;
		r.pct      = held_pct;
		r.flapping = flap_on;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_LOW_THR:   thr_low    = val[PCT_W-1:0];
			CFG_HIGH_THR:  thr_high   = val[PCT_W-1:0];
			CFG_TRACK_MSK: track_mask = val[MASK_W-1:0];
			CFG_DETECT_EN: det_en     = val[0];
			default: ;
		endcase
	endfunction

	function automatic void add_req(obs_t st, logic soft_in, logic upd, logic typed,
			flap_res_t res);
		dir_row_t row;
		row = '0;
		row.kind      = ROW_REQ;
		row.st        = st;
		row.soft_flag = soft_in;
		row.upd       = upd;
		row.typed     = typed;
		row.res       = res;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row = '0;
		row.kind    = ROW_CFG;
		row.reg_idx = idx;
		row.wdata   = val;
		dir_rows.push_back(row);
	endfunction

	// register write, one cycle with the enable high; the task drops it again before it returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(input int lo, input int hi, input int msk, input int en);
		write_reg(CFG_LOW_THR, CFG_DATA_W'(lo));
		write_reg(CFG_HIGH_THR, CFG_DATA_W'(hi));
		write_reg(CFG_TRACK_MSK, CFG_DATA_W'(msk));
		write_reg(CFG_DETECT_EN, CFG_DATA_W'(en));
	endtask

	// offer one request; valid stays high on return so back-to-back requests
	// never see it dropped and raised in the same step
	task automatic send_req(input obs_t st, input logic soft_in, input logic upd,
			input logic typed, input flap_res_t typed_res);
		flap_res_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		obs_state <= st;
		soft_req  <= soft_in;
		update    <= upd;
		do @(posedge clk); while (!in_ready);
		res = flap_update(st, soft_in, upd);
		pending_results.push_back(typed ? typed_res : res);
		if (!(soft_in && st != ST_OK))
			scored_reqs++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic int pick_thr();
		case ($urandom_range(3))
			0:       return 0;
			1:       return PCT_MAX;
			default: return $urandom_range(PCT_MAX);
		endcase
	endfunction

	// random traffic: mostly flap bursts and steady runs, some noise
	task automatic run_segment(input int n_reqs);
		int   target;
		int   kind;
		int   len;
		obs_t st;
		obs_t nxt;
		target = scored_reqs + n_reqs;
		st = obs_t'($urandom_range(3));
		while (scored_reqs < target) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// alternating hard updates, long runs fill the whole ring
				len = $urandom_range(4, 30);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 85)
						nxt = obs_t'((st + $urandom_range(1, 3)) % 4);
					else
						nxt = st;
					send_req(nxt, 1'b0, 1'b1, 1'b0, '0);
					st = nxt;
				end
			end else if (kind < 85) begin
				// steady run lets the percent decay and the flag stop
				len = $urandom_range(3, 25);
				st  = obs_t'($urandom_range(3));
				for (int i = 0; i < len; i++)
					send_req(st, ($urandom_range(9) == 0) && (st == ST_OK),
						$urandom_range(9) != 0, 1'b0, '0);
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_req(obs_t'($urandom_range(3)), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'b0, '0);
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_done;
		hold_done = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		flap_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: change_pct %0d",
					change_pct);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (change_pct !== want.pct) begin
					$error("change_pct: expected %0d, actual %0d",
						want.pct, change_pct);
					fails++;
				end
				if (flapping !== want.flapping) begin
					$error("flapping: expected %0b, actual %0b", want.flapping, flapping);
					fails++;
				end
				if (started !== want.started) begin
					$error("started: expected %0b, actual %0b", want.started, started);
					fails++;
				end
				if (stopped !== want.stopped) begin
					$error("stopped: expected %0b, actual %0b", want.stopped, stopped);
					fails++;
				end
				if (ignored !== want.ignored) begin
					$error("ignored: expected %0b, actual %0b", want.ignored, ignored);
					fails++;
				end
			end
		end
	end

	initial begin
		flap_res_t quiet;
		flap_res_t skipped;
		dir_row_t  row;

		for (int i = 0; i < DEPTH; i++)
			ring[i] = ST_OK;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_LOW_THR;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		obs_state <= ST_OK;
		soft_req  <= 1'b0;
		update    <= 1'b0;

		quiet   = '0;
		skipped = '0;
		skipped.ignored = 1'b1;

		// after reset the ring is all ok: nothing changes, nothing flaps
		add_req(ST_OK,       1'b0, 1'b1, 1'b1, quiet);
		// soft non-ok of every kind is skipped
		add_req(ST_WARNING,  1'b1, 1'b1, 1'b1, skipped);
		add_req(ST_CRITICAL, 1'b1, 1'b0, 1'b1, skipped);
		add_req(ST_UNKNOWN,  1'b1, 1'b1, 1'b1, skipped);
		// soft ok still counts
		add_req(ST_OK,       1'b1, 1'b1, 1'b1, quiet);
		// re-evaluate only, history untouched
		add_req(ST_WARNING,  1'b0, 1'b0, 1'b1, quiet);
		// alternate states so that the flag starts
		add_req(ST_WARNING,  1'b0, 1'b1, 1'b0, quiet);
		add_req(ST_OK,       1'b0, 1'b1, 1'b0, quiet);
		add_req(ST_CRITICAL, 1'b0, 1'b1, 1'b0, quiet);
		add_req(ST_UNKNOWN,  1'b0, 1'b1, 1'b0, quiet);
		add_req(ST_OK,       1'b0, 1'b1, 1'b0, quiet);
		// skipped while flapping keeps the flag
		add_req(ST_CRITICAL, 1'b1, 1'b1, 1'b0, quiet);
		// crossed thresholds at the extremes: low side clears first
		add_cfg(CFG_LOW_THR,  CFG_DATA_W'(PCT_MAX));
		add_cfg(CFG_HIGH_THR, '0);
		add_req(ST_OK,       1'b0, 1'b0, 1'b0, quiet);
		// nothing tracked: update is dropped, percent recomputed
		add_cfg(CFG_TRACK_MSK, '0);
		add_req(ST_UNKNOWN,  1'b0, 1'b1, 1'b0, quiet);
		// both thresholds at zero: any change sets the flag
		add_cfg(CFG_LOW_THR, '0);
		add_req(ST_OK,       1'b0, 1'b0, 1'b0, quiet);
		// detection off: flag forced low without a stop
		add_cfg(CFG_DETECT_EN, '0);
		add_req(ST_OK,       1'b0, 1'b0, 1'b0, quiet);
		add_req(ST_WARNING,  1'b1, 1'b0, 1'b0, quiet);
		// back to the reset settings
		add_cfg(CFG_DETECT_EN, CFG_DATA_W'(1));
		add_cfg(CFG_TRACK_MSK, CFG_DATA_W'(15));
		add_cfg(CFG_LOW_THR,   CFG_DATA_W'(1280));
		add_cfg(CFG_HIGH_THR,  CFG_DATA_W'(5120));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				drain();
				write_reg(row.reg_idx, row.wdata);
			end else begin
				send_req(row.st, row.soft_flag, row.upd, row.typed, row.res);
			end
		end

		// random part: four idle patterns, two settings each
		for (int seg = 0; seg < N_SEGS; seg++) begin
			drain();
			case (seg)
				0:       configure(1280, 5120, 15, 1);
				1:       configure(0, PCT_MAX, 15, 1);
				2:       configure(PCT_MAX, 0, 7, 1);
				default: configure(pick_thr(), pick_thr(), $urandom_range(15),
						$urandom_range(3) != 0);
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct  = 27;
					recv_stall_pct = 27;
				end
			endcase
			// long receiver hold-off while requests keep coming, fills the unit
			if (seg == 1)
				hold_req++;
			run_segment(SEG_REQS);
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fails == 0)
			$display("weighted_flap_detector_unit: match");
		else
			$display("weighted_flap_detector_unit: mismatch");
		$finish;
	end

endmodule

[files.f]
sv/wfd_pkg.sv
sv/wfd_dp.sv
sv/wfd_ctrl.sv
sv/weighted_flap_detector_unit.sv
sv/wfd_checker.sv
dv/tb_weighted_flap_detector_unit.sv
